@@ rtl/tpr_pkg.sv @@
// ----------------------------------------------------------------------------
// tpr_pkg: shared types and constants for the pump run controller
// Request and stop-cause codes, field widths and the item structs.
// ----------------------------------------------------------------------------
package tpr_pkg;

  localparam int unsigned TICKS_PER_SECOND = 1000;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned SEC_W  = 16;
  localparam int unsigned MS_W   = 10;
  localparam int unsigned RATE_W = 16;
  localparam int unsigned VOL_W  = 16;
  localparam int unsigned CAUSE_W = 3;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(256);

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK       = 3'd0,
    REQ_TRIGGER    = 3'd1,
    REQ_DIRECT_ON  = 3'd2,
    REQ_DIRECT_OFF = 3'd3,
    REQ_STOP       = 3'd4,
    REQ_QUERY      = 3'd5
  } req_type_e;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_TIMEOUT  = 3'd1,
    CAUSE_GDISABLE = 3'd2,
    CAUSE_MANUAL   = 3'd3,
    CAUSE_DIRECT   = 3'd4
  } stop_cause_e;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [SEC_W-1:0] duration_seconds;
    logic             global_enable;
  } req_t;

  typedef struct packed {
    logic               relay_on;
    logic               direct_active;
    logic               accepted;
    logic [CAUSE_W-1:0] stop_cause;
    logic [SEC_W-1:0]   run_seconds;
    logic [VOL_W-1:0]   volume_ml;
    logic [SEC_W-1:0]   remaining_seconds;
  } rsp_t;

endpackage

@@ rtl/tpr_if.sv @@
// ----------------------------------------------------------------------------
// tpr_if: channel interfaces of the pump run controller
// Request, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpr_req_if;
  logic                        valid;
  logic                        ready;
  logic [tpr_pkg::REQ_W-1:0]   req_type;
  logic [tpr_pkg::SEC_W-1:0]   duration_seconds;
  logic                        global_enable;

  modport source (output valid, req_type, duration_seconds, global_enable, input ready);
  modport sink   (input valid, req_type, duration_seconds, global_enable, output ready);
endinterface

interface tpr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         relay_on;
  logic                         direct_active;
  logic                         accepted;
  logic [tpr_pkg::CAUSE_W-1:0]  stop_cause;
  logic [tpr_pkg::SEC_W-1:0]    run_seconds;
  logic [tpr_pkg::VOL_W-1:0]    volume_ml;
  logic [tpr_pkg::SEC_W-1:0]    remaining_seconds;

  modport source (output valid, relay_on, direct_active, accepted, stop_cause,
                  run_seconds, volume_ml, remaining_seconds, input ready);
  modport sink   (input valid, relay_on, direct_active, accepted, stop_cause,
                  run_seconds, volume_ml, remaining_seconds, output ready);
endinterface

interface tpr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tpr_pkg::RATE_W-1:0]  volume_rate;

  modport source (output valid, volume_rate, input ready);
  modport sink   (input valid, volume_rate, output ready);
endinterface

@@ rtl/tpr_in_stage.sv @@
// ----------------------------------------------------------------------------
// tpr_in_stage: request input register
// Holds one request item; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module tpr_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  tpr_pkg::req_t req_i,
  output logic          valid_o,
  input  logic          take_i,
  output tpr_pkg::req_t req_o
);

  logic          valid_q;
  tpr_pkg::req_t req_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign req_o   = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      req_q <= req_i;
    end
  end

endmodule

@@ rtl/tpr_volume.sv @@
// ----------------------------------------------------------------------------
// tpr_volume: volume estimate
// seconds * Q8.8 rate, rounded half up, saturated to 16 bits.
// ----------------------------------------------------------------------------
module tpr_volume (
  input  logic [tpr_pkg::SEC_W-1:0]  seconds_i,
  input  logic [tpr_pkg::RATE_W-1:0] rate_i,
  output logic [tpr_pkg::VOL_W-1:0]  volume_o
);

  localparam int unsigned PROD_W = tpr_pkg::SEC_W + tpr_pkg::RATE_W;

  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   rounded;
  logic [PROD_W-9:0]   scaled;

  // max product + 128 still fits in PROD_W bits
  assign prod    = PROD_W'(seconds_i) * PROD_W'(rate_i);
  assign rounded = prod + PROD_W'(128);
  assign scaled  = rounded[PROD_W-1:8];

  always_comb begin
    if (|scaled[PROD_W-9:tpr_pkg::VOL_W]) begin
      volume_o = '1;
    end else begin
      volume_o = scaled[tpr_pkg::VOL_W-1:0];
    end
  end

endmodule

@@ rtl/tpr_core.sv @@
// ----------------------------------------------------------------------------
// tpr_core: run state, request decode and result register
// One request item per cycle, while the result register can take it, updates the run state and loads one result.
// ----------------------------------------------------------------------------
module tpr_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  tpr_pkg::req_t              req_i,
  output logic                       take_o,
  input  logic                       cfg_we_i,
  input  logic [tpr_pkg::RATE_W-1:0] cfg_rate_i,
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  output tpr_pkg::rsp_t              rsp_o
);

  localparam int unsigned SEC_W = tpr_pkg::SEC_W;
  localparam int unsigned MS_W  = tpr_pkg::MS_W;

  logic                     running_q, running_d;
  logic                     direct_q, direct_d;
  logic [SEC_W-1:0]         esec_q, esec_d;
  logic [MS_W-1:0]          ems_q, ems_d;
  logic [SEC_W-1:0]         len_q, len_d;
  logic [tpr_pkg::RATE_W-1:0] rate_q;

  logic                     rsp_valid_q;
  tpr_pkg::rsp_t            rsp_q, rsp_d;

  logic [MS_W:0]            ms_inc;
  logic [SEC_W-1:0]         rsec;
  logic [tpr_pkg::VOL_W-1:0] vol;

  assign take_o      = in_valid_i && (!rsp_valid_q || rsp_ready_i);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign ms_inc = {1'b0, ems_q} + (MS_W+1)'(1);

  tpr_volume u_volume (
    .seconds_i (rsec),
    .rate_i    (rate_q),
    .volume_o  (vol)
  );

  always_comb begin
    running_d = running_q;
    direct_d  = direct_q;
    esec_d    = esec_q;
    ems_d     = ems_q;
    len_d     = len_q;
    rsec      = '0;
    rsp_d     = '0;
    case (req_i.req_type)
      tpr_pkg::REQ_TICK: begin
        if (running_q) begin
          if (!direct_q && !req_i.global_enable) begin
            running_d        = 1'b0;
            rsp_d.stop_cause = tpr_pkg::CAUSE_GDISABLE;
          end else begin
            if (ms_inc >= (MS_W+1)'(tpr_pkg::TICKS_PER_SECOND)) begin
              ems_d = '0;
              if (esec_q != '1) begin
                esec_d = esec_q + SEC_W'(1);
              end
            end else begin
              ems_d = ms_inc[MS_W-1:0];
            end
            if (esec_d >= len_q) begin
              running_d        = 1'b0;
              direct_d         = 1'b0;
              rsp_d.stop_cause = tpr_pkg::CAUSE_TIMEOUT;
              rsec             = esec_d;
            end
          end
        end
      end
      tpr_pkg::REQ_TRIGGER: begin
        if (!running_q && req_i.global_enable) begin
          running_d      = 1'b1;
          direct_d       = 1'b0;
          esec_d         = '0;
          ems_d          = '0;
          len_d          = req_i.duration_seconds;
          rsp_d.accepted = 1'b1;
        end
      end
      tpr_pkg::REQ_DIRECT_ON: begin
        if (running_q) begin
          rsp_d.accepted = direct_q;
        end else begin
          running_d      = 1'b1;
          direct_d       = 1'b1;
          esec_d         = '0;
          ems_d          = '0;
          len_d          = req_i.duration_seconds;
          rsp_d.accepted = 1'b1;
        end
      end
      tpr_pkg::REQ_DIRECT_OFF: begin
        if (running_q && direct_q) begin
          running_d        = 1'b0;
          direct_d         = 1'b0;
          rsp_d.stop_cause = tpr_pkg::CAUSE_DIRECT;
        end
      end
      tpr_pkg::REQ_STOP: begin
        if (running_q) begin
          running_d        = 1'b0;
          direct_d         = 1'b0;
          rsp_d.stop_cause = tpr_pkg::CAUSE_MANUAL;
          rsec             = esec_q;
        end
      end
      default: begin
      end
    endcase

    rsp_d.relay_on      = running_d;
    rsp_d.direct_active = direct_d;
    rsp_d.run_seconds   = rsec;
    rsp_d.volume_ml     = vol;
    // a started second counts as spent
    if (!running_d || esec_d >= len_d) begin
      rsp_d.remaining_seconds = '0;
    end else begin
      rsp_d.remaining_seconds = len_d - esec_d - SEC_W'(ems_d != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      direct_q    <= 1'b0;
      esec_q      <= '0;
      ems_q       <= '0;
      len_q       <= '0;
      rate_q      <= tpr_pkg::RATE_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_rate_i;
      end
      if (take_o) begin
        running_q <= running_d;
        direct_q  <= direct_d;
        esec_q    <= esec_d;
        ems_q     <= ems_d;
        len_q     <= len_d;
      end
      if (take_o) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

@@ rtl/timed_pump_run_controller.sv @@
// ----------------------------------------------------------------------------
// timed_pump_run_controller: relay timer for a pump
// Normal and direct runs, millisecond ticks, timeout and stop reporting.
// ----------------------------------------------------------------------------
// Usage:
//  - req carries one request item: a 1 ms tick, trigger, direct on/off,
//    stop or query, with the run length and the global enable level.
//  - rsp returns exactly one result item per request item, in order:
//    relay state, mode, accept flag, stop cause, seconds run, volume
//    estimate and seconds remaining.
//  - cfg writes the Q8.8 volume rate (ml/s); it is always ready. Write it
//    only while no request item is in flight.
//  - An accepted request passes through the input register, then the
//    run-state update into the result register, before its result is on rsp.
//  - Throughput: one item per cycle while rsp takes results; the run state
//    is a single set of registers updated once per item.
//  - A stalled rsp holds its result; req keeps accepting until the input
//    register is full too, then ready drops until rsp drains.
//  - Reset: idle, no run, counters zero, volume rate 1.0 ml/s (256).
// ----------------------------------------------------------------------------
module timed_pump_run_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  tpr_req_if.sink        req,
  tpr_rsp_if.source      rsp,
  tpr_cfg_if.sink        cfg
);

  tpr_pkg::req_t in_req;
  tpr_pkg::req_t stage_req;
  tpr_pkg::rsp_t core_rsp;
  logic          stage_valid;
  logic          take;

  assign in_req.req_type         = req.req_type;
  assign in_req.duration_seconds = req.duration_seconds;
  assign in_req.global_enable    = req.global_enable;

  // config register never back-pressures
  assign cfg.ready = 1'b1;

  tpr_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req.valid),
    .ready_o (req.ready),
    .req_i   (in_req),
    .valid_o (stage_valid),
    .take_i  (take),
    .req_o   (stage_req)
  );

  tpr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stage_valid),
    .req_i       (stage_req),
    .take_o      (take),
    .cfg_we_i    (cfg.valid),
    .cfg_rate_i  (cfg.volume_rate),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .rsp_o       (core_rsp)
  );

  // result item fields
  assign rsp.relay_on          = core_rsp.relay_on;
  assign rsp.direct_active     = core_rsp.direct_active;
  assign rsp.accepted          = core_rsp.accepted;
  assign rsp.stop_cause        = core_rsp.stop_cause;
  assign rsp.run_seconds       = core_rsp.run_seconds;
  assign rsp.volume_ml         = core_rsp.volume_ml;
  assign rsp.remaining_seconds = core_rsp.remaining_seconds;

endmodule

@@ rtl/tpr_checker.sv @@
// ----------------------------------------------------------------------------
// tpr_checker: port-level checks for the pump run controller
// Result consistency and output hold under stall.
// ----------------------------------------------------------------------------
module tpr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        relay_on_i,
  input logic                        direct_active_i,
  input logic                        accepted_i,
  input logic [tpr_pkg::CAUSE_W-1:0] stop_cause_i,
  input logic [tpr_pkg::SEC_W-1:0]   run_seconds_i,
  input logic [tpr_pkg::SEC_W-1:0]   remaining_seconds_i
);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(remaining_seconds_i)
      && $stable(stop_cause_i) && $stable(relay_on_i))
    else $error("result changed while stalled");

  a_direct_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && direct_active_i |-> relay_on_i)
    else $error("direct mode without running relay");

  a_idle_no_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !relay_on_i |-> remaining_seconds_i == '0)
    else $error("remaining time while idle");

  a_stop_clears_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (stop_cause_i != tpr_pkg::CAUSE_NONE) |-> !relay_on_i && !accepted_i)
    else $error("stop reported with relay still on");

  a_run_seconds_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (run_seconds_i != '0) |->
      (stop_cause_i == tpr_pkg::CAUSE_TIMEOUT) || (stop_cause_i == tpr_pkg::CAUSE_MANUAL))
    else $error("run seconds without timeout or manual stop");

endmodule

bind timed_pump_run_controller tpr_checker u_tpr_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .rsp_valid_i         (rsp.valid),
  .rsp_ready_i         (rsp.ready),
  .relay_on_i          (rsp.relay_on),
  .direct_active_i     (rsp.direct_active),
  .accepted_i          (rsp.accepted),
  .stop_cause_i        (rsp.stop_cause),
  .run_seconds_i       (rsp.run_seconds),
  .remaining_seconds_i (rsp.remaining_seconds)
);
